[rtl/cpu16_execute_unit_assert.svh]
// Assertion macros for the cpu16 execute unit.
`ifndef CPU16_EXECUTE_UNIT_ASSERT_SVH
`define CPU16_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CPU16EU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cpu16eu assertion failed");

`define CPU16EU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("cpu16eu forbidden condition");

`else

`define CPU16EU_ASSERT(lbl, clk, rst_n, prop)

`define CPU16EU_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[rtl/cpu16eu_pkg.sv]
package cpu16eu_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;
  localparam int NUM_GP = 8;
  localparam int GP_IDX_BITS = 3;

  typedef enum logic [2:0] {
    KIND_MOV,
    KIND_ADD,
    KIND_SUB,
    KIND_CMP,
    KIND_JNZ,
    KIND_JMP
  } kind_e;

  typedef enum logic [2:0] {
    OPND_REG,
    OPND_SEG,
    OPND_IMM,
    OPND_DIRECT,
    OPND_EA
  } opnd_e;

  typedef enum logic [1:0] {
    PART_FULL,
    PART_LO,
    PART_HI
  } part_e;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;

  localparam logic [GP_IDX_BITS-1:0] VIEW_REG [16] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
  };

  localparam part_e VIEW_PART [16] = '{
    PART_FULL, PART_LO, PART_HI, PART_FULL, PART_LO, PART_HI,
    PART_FULL, PART_LO, PART_HI, PART_FULL, PART_LO, PART_HI,
    PART_FULL, PART_FULL, PART_FULL, PART_FULL
  };

  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        dst_kind;
    logic [2:0]        src_kind;
    logic [3:0]        dst_sel;
    logic [3:0]        src_sel;
    logic [4:0]        base_sel;
    logic [4:0]        index_sel;
    logic signed [15:0] displacement;
    logic [15:0]       immediate;
    logic [15:0]       direct_address;
    logic [2:0]        length;
  } instr_t;

  typedef struct packed {
    logic [3:0] dst_sel;
    logic [3:0] src_sel;
    logic [4:0] base_sel;
    logic [4:0] index_sel;
  } rf_sel_t;

  typedef struct packed {
    logic                   en;
    logic [GP_IDX_BITS-1:0] idx;
    logic [15:0]            data;
  } rf_wr_t;

  typedef struct packed {
    logic [15:0] dst_full;
    logic [15:0] src_view;
    logic [15:0] base_view;
    logic [15:0] index_view;
  } rf_data_t;

  typedef struct packed {
    instr_t      ins;
    logic [15:0] dst_full;
    logic [15:0] src_view;
    logic [15:0] seg_val;
    logic [7:0]  mem_byte;
    logic [15:0] ip;
    logic        zf;
    logic        sf;
  } alu_in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
    logic [15:0] result;
    logic [15:0] next_ip;
    logic        zf;
    logic        sf;
    rf_wr_t      gp_wr;
    logic        seg_we;
    logic        mem_we;
  } alu_out_t;

  function automatic logic [15:0] view_get(logic [15:0] full, logic [3:0] sel);
    logic [15:0] r;
    case (VIEW_PART[sel])
      PART_LO: r = {8'h00, full[7:0]};
      PART_HI: r = {8'h00, full[15:8]};
      default: r = full;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] view_put(logic [15:0] old, logic [3:0] sel,
                                           logic [15:0] val);
    logic [15:0] r;
    case (VIEW_PART[sel])
      PART_LO: r = {old[15:8], val[7:0]};
      PART_HI: r = {val[7:0], old[7:0]};
      default: r = val;
    endcase
    return r;
  endfunction

endpackage

[rtl/cpu16eu_if.sv]
interface cpu16eu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [2:0]         dst_kind;
  logic [2:0]         src_kind;
  logic [3:0]         dst_sel;
  logic [3:0]         src_sel;
  logic [4:0]         base_sel;
  logic [4:0]         index_sel;
  logic signed [15:0] displacement;
  logic [15:0]        immediate;
  logic [15:0]        direct_address;
  logic [2:0]         length;

  modport source (
    output valid, kind, dst_kind, src_kind, dst_sel, src_sel, base_sel, index_sel,
           displacement, immediate, direct_address, length,
    input  ready
  );

  modport sink (
    input  valid, kind, dst_kind, src_kind, dst_sel, src_sel, base_sel, index_sel,
           displacement, immediate, direct_address, length,
    output ready
  );
endinterface

interface cpu16eu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_ip;
  logic        zero_out;
  logic        sign_out;
  logic [15:0] result_value;
  logic        status;

  modport source (
    output valid, next_ip, zero_out, sign_out, result_value, status,
    input  ready
  );

  modport sink (
    input  valid, next_ip, zero_out, sign_out, result_value, status,
    output ready
  );
endinterface

[rtl/cpu16eu_ram.sv]
module cpu16eu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cpu16eu_regfile.sv]
module cpu16eu_regfile (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  cpu16eu_pkg::rf_sel_t  rd_sel_i,
  input  cpu16eu_pkg::rf_wr_t   wr_i,
  output cpu16eu_pkg::rf_data_t data_o
);

  localparam int NPORT = 4;

  cpu16eu_pkg::rf_sel_t sel_q;
  cpu16eu_pkg::rf_wr_t  last_q;
  logic [cpu16eu_pkg::NUM_GP-1:0] valid_q;

  logic [cpu16eu_pkg::GP_IDX_BITS-1:0] raddr [NPORT];
  logic [cpu16eu_pkg::GP_IDX_BITS-1:0] ridx  [NPORT];
  logic [15:0] rdata [NPORT];
  logic [15:0] full  [NPORT];

  assign raddr[0] = cpu16eu_pkg::VIEW_REG[rd_sel_i.dst_sel];
  assign raddr[1] = cpu16eu_pkg::VIEW_REG[rd_sel_i.src_sel];
  assign raddr[2] = cpu16eu_pkg::VIEW_REG[rd_sel_i.base_sel[3:0]];
  assign raddr[3] = cpu16eu_pkg::VIEW_REG[rd_sel_i.index_sel[3:0]];

  assign ridx[0] = cpu16eu_pkg::VIEW_REG[sel_q.dst_sel];
  assign ridx[1] = cpu16eu_pkg::VIEW_REG[sel_q.src_sel];
  assign ridx[2] = cpu16eu_pkg::VIEW_REG[sel_q.base_sel[3:0]];
  assign ridx[3] = cpu16eu_pkg::VIEW_REG[sel_q.index_sel[3:0]];

  for (genvar g = 0; g < NPORT; g++) begin : g_copy
    cpu16eu_ram #(
      .WIDTH(16),
      .DEPTH(cpu16eu_pkg::NUM_GP)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_i.en),
      .waddr_i (wr_i.idx),
      .wdata_i (wr_i.data),
      .re_i    (rd_en_i),
      .raddr_i (raddr[g]),
      .rdata_o (rdata[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sel_q <= rd_sel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      last_q  <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
      last_q            <= wr_i;
    end
  end

  // forward the most recent write, unwritten entries read as zero
  always_comb begin
    for (int p = 0; p < NPORT; p++) begin
      if (last_q.en && (last_q.idx == ridx[p])) begin
        full[p] = last_q.data;
      end else if (valid_q[ridx[p]]) begin
        full[p] = rdata[p];
      end else begin
        full[p] = '0;
      end
    end
  end

  always_comb begin
    data_o.dst_full   = full[0];
    data_o.src_view   = cpu16eu_pkg::view_get(full[1], sel_q.src_sel);
    data_o.base_view  = sel_q.base_sel[4] ? 16'h0000 :
                        cpu16eu_pkg::view_get(full[2], sel_q.base_sel[3:0]);
    data_o.index_view = sel_q.index_sel[4] ? 16'h0000 :
                        cpu16eu_pkg::view_get(full[3], sel_q.index_sel[3:0]);
  end

endmodule

[rtl/cpu16eu_alu.sv]
module cpu16eu_alu (
  input  cpu16eu_pkg::alu_in_t  op_i,
  output cpu16eu_pkg::alu_out_t res_o
);

  logic [2:0]  kind;
  logic [2:0]  dk;
  logic [2:0]  sk;
  logic [15:0] srcv;
  logic [15:0] dview;

  assign kind  = op_i.ins.kind;
  assign dk    = op_i.ins.dst_kind;
  assign sk    = op_i.ins.src_kind;
  assign dview = cpu16eu_pkg::view_get(op_i.dst_full, op_i.ins.dst_sel);

  always_comb begin
    case (sk)
      cpu16eu_pkg::OPND_REG:    srcv = op_i.src_view;
      cpu16eu_pkg::OPND_SEG:    srcv = op_i.seg_val;
      cpu16eu_pkg::OPND_IMM:    srcv = op_i.ins.immediate;
      cpu16eu_pkg::OPND_DIRECT: srcv = {8'h00, op_i.mem_byte};
      cpu16eu_pkg::OPND_EA:     srcv = {8'h00, op_i.mem_byte};
      default:                  srcv = '0;
    endcase
  end

  always_comb begin
    logic        ok;
    logic [15:0] v;
    logic        setf;
    logic        gp_we;
    logic        seg_we;
    logic        mem_we;
    logic        jump;
    ok     = 1'b0;
    v      = '0;
    setf   = 1'b0;
    gp_we  = 1'b0;
    seg_we = 1'b0;
    mem_we = 1'b0;
    jump   = 1'b0;
    case (kind)
      cpu16eu_pkg::KIND_MOV: begin
        v = srcv;
        case (dk)
          cpu16eu_pkg::OPND_REG: begin
            ok = sk inside {cpu16eu_pkg::OPND_REG, cpu16eu_pkg::OPND_SEG,
                            cpu16eu_pkg::OPND_IMM, cpu16eu_pkg::OPND_DIRECT,
                            cpu16eu_pkg::OPND_EA};
            gp_we = 1'b1;
          end
          cpu16eu_pkg::OPND_SEG: begin
            ok = sk inside {cpu16eu_pkg::OPND_REG, cpu16eu_pkg::OPND_SEG,
                            cpu16eu_pkg::OPND_IMM};
            seg_we = 1'b1;
          end
          cpu16eu_pkg::OPND_DIRECT: begin
            ok = (sk == cpu16eu_pkg::OPND_IMM);
            mem_we = 1'b1;
          end
          cpu16eu_pkg::OPND_EA: begin
            ok = sk inside {cpu16eu_pkg::OPND_REG, cpu16eu_pkg::OPND_IMM};
            mem_we = 1'b1;
          end
          default: ok = 1'b0;
        endcase
      end
      cpu16eu_pkg::KIND_ADD: begin
        ok = (dk == cpu16eu_pkg::OPND_REG) &&
             (sk inside {cpu16eu_pkg::OPND_REG, cpu16eu_pkg::OPND_IMM,
                         cpu16eu_pkg::OPND_EA});
        v     = dview + srcv;
        setf  = (sk != cpu16eu_pkg::OPND_EA);
        gp_we = 1'b1;
      end
      cpu16eu_pkg::KIND_SUB, cpu16eu_pkg::KIND_CMP: begin
        ok = (dk == cpu16eu_pkg::OPND_REG) &&
             (sk inside {cpu16eu_pkg::OPND_REG, cpu16eu_pkg::OPND_IMM});
        v     = dview - srcv;
        setf  = 1'b1;
        gp_we = (kind == cpu16eu_pkg::KIND_SUB);
      end
      cpu16eu_pkg::KIND_JNZ: begin
        ok   = 1'b1;
        jump = !op_i.zf;
      end
      default: ok = 1'b0;
    endcase

    res_o.ok     = ok;
    res_o.value  = v;
    res_o.result = ok ? v : 16'h0000;
    res_o.zf     = (ok && setf) ? (v == 16'h0000) : op_i.zf;
    res_o.sf     = (ok && setf) ? v[15] : op_i.sf;
    res_o.next_ip = ok ? (op_i.ip + 16'(op_i.ins.length) +
                          (jump ? op_i.ins.immediate : 16'h0000)) : op_i.ip;
    res_o.gp_wr.en   = ok && gp_we;
    res_o.gp_wr.idx  = cpu16eu_pkg::VIEW_REG[op_i.ins.dst_sel];
    res_o.gp_wr.data = cpu16eu_pkg::view_put(op_i.dst_full, op_i.ins.dst_sel, v);
    res_o.seg_we = ok && seg_we;
    res_o.mem_we = ok && mem_we;
  end

endmodule

[rtl/cpu16_execute_unit.sv]
// Pipeline: register file read, data memory read and execute registers lie between input
// transfer and result valid; a result not taken at the output holds the execute stage.
// A new instruction waits until the previous one leaves register read and can leave memory read.
// Reset: registers, flags and instruction pointer clear at once; the data memory is then
// zeroed one byte per cycle over all 2**MEM_ADDR_BITS bytes, with no input accepted meanwhile.
`include "cpu16_execute_unit_assert.svh"

module cpu16_execute_unit #(
  parameter int MEM_ADDR_BITS = cpu16eu_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpu16eu_in_if.sink           in_i,
  cpu16eu_out_if.source        out_o
);

  localparam int MEM_DEPTH = 2 ** MEM_ADDR_BITS;

  typedef struct packed {
    cpu16eu_pkg::instr_t ins;
    logic [15:0]         dst_full;
    logic [15:0]         src_view;
    logic [15:0]         ea;
  } s2_t;

  cpu16eu_pkg::instr_t   in_ins;
  cpu16eu_pkg::rf_sel_t  rf_sel;
  cpu16eu_pkg::rf_data_t rf_data;
  cpu16eu_pkg::rf_wr_t   rf_wr;
  cpu16eu_pkg::alu_in_t  alu_in;
  cpu16eu_pkg::alu_out_t alu_out;

  cpu16eu_pkg::instr_t s1_q;
  s2_t                 s2_q;
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic clearing_q;
  logic [MEM_ADDR_BITS-1:0] clr_addr_q;
  logic [15:0] ip_q;
  logic zf_q, sf_q;
  logic [15:0] seg_q [4];
  logic [15:0] out_ip_q, out_res_q;
  logic out_zf_q, out_sf_q, out_status_q;

  logic in_fire, s2_adv;
  logic [15:0] ea;
  logic [MEM_ADDR_BITS-1:0] mem_raddr, mem_waddr, mem_wa;
  logic [7:0] mem_rdata, mem_wd;
  logic mem_we;

  assign s2_adv     = s2_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clearing_q && !s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_ins.kind           = in_i.kind;
    in_ins.dst_kind       = in_i.dst_kind;
    in_ins.src_kind       = in_i.src_kind;
    in_ins.dst_sel        = in_i.dst_sel;
    in_ins.src_sel        = in_i.src_sel;
    in_ins.base_sel       = in_i.base_sel;
    in_ins.index_sel      = in_i.index_sel;
    in_ins.displacement   = in_i.displacement;
    in_ins.immediate      = in_i.immediate;
    in_ins.direct_address = in_i.direct_address;
    in_ins.length         = in_i.length;
    rf_sel.dst_sel        = in_i.dst_sel;
    rf_sel.src_sel        = in_i.src_sel;
    rf_sel.base_sel       = in_i.base_sel;
    rf_sel.index_sel      = in_i.index_sel;
  end

  cpu16eu_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_sel_i (rf_sel),
    .wr_i     (rf_wr),
    .data_o   (rf_data)
  );

  assign ea = rf_data.base_view + rf_data.index_view + $unsigned(s1_q.displacement);
  assign mem_raddr = (s1_q.src_kind == cpu16eu_pkg::OPND_DIRECT) ?
                     s1_q.direct_address[MEM_ADDR_BITS-1:0] : ea[MEM_ADDR_BITS-1:0];
  assign mem_waddr = (s2_q.ins.dst_kind == cpu16eu_pkg::OPND_DIRECT) ?
                     s2_q.ins.direct_address[MEM_ADDR_BITS-1:0] :
                     s2_q.ea[MEM_ADDR_BITS-1:0];

  always_comb begin
    if (clearing_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = 8'h00;
    end else begin
      mem_we = s2_adv && alu_out.mem_we;
      mem_wa = mem_waddr;
      mem_wd = alu_out.value[7:0];
    end
  end

  cpu16eu_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_data_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (s1_valid_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    alu_in.ins      = s2_q.ins;
    alu_in.dst_full = s2_q.dst_full;
    alu_in.src_view = s2_q.src_view;
    alu_in.seg_val  = seg_q[s2_q.ins.src_sel[1:0]];
    alu_in.mem_byte = mem_rdata;
    alu_in.ip       = ip_q;
    alu_in.zf       = zf_q;
    alu_in.sf       = sf_q;
  end

  cpu16eu_alu u_alu (
    .op_i  (alu_in),
    .res_o (alu_out)
  );

  always_comb begin
    rf_wr    = alu_out.gp_wr;
    rf_wr.en = alu_out.gp_wr.en && s2_adv;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_ins;
    end
    if (s1_valid_q) begin
      s2_q.ins      <= s1_q;
      s2_q.dst_full <= rf_data.dst_full;
      s2_q.src_view <= rf_data.src_view;
      s2_q.ea       <= ea;
    end
    if (s2_adv) begin
      out_ip_q     <= alu_out.next_ip;
      out_zf_q     <= alu_out.zf;
      out_sf_q     <= alu_out.sf;
      out_res_q    <= alu_out.result;
      out_status_q <= alu_out.ok ? cpu16eu_pkg::STATUS_OK : cpu16eu_pkg::STATUS_UNSUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      ip_q        <= '0;
      zf_q        <= 1'b0;
      sf_q        <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        seg_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= in_fire;
      if (s1_valid_q) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          clearing_q <= 1'b0;
        end
      end
      if (s2_adv) begin
        ip_q <= alu_out.next_ip;
        zf_q <= alu_out.zf;
        sf_q <= alu_out.sf;
        if (alu_out.seg_we) begin
          seg_q[s2_q.ins.dst_sel[1:0]] <= alu_out.value;
        end
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_ip      = out_ip_q;
  assign out_o.zero_out     = out_zf_q;
  assign out_o.sign_out     = out_sf_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status       = out_status_q;

  `CPU16EU_ASSERT_NEVER(a_one_in_flight, clk_i, rst_ni, s1_valid_q && s2_valid_q)
  `CPU16EU_ASSERT_NEVER(a_no_take_clearing, clk_i, rst_ni, clearing_q && in_fire)
  `CPU16EU_ASSERT(a_s1_advances, clk_i, rst_ni, s1_valid_q |=> s2_valid_q)
  `CPU16EU_ASSERT(a_stall_out_full, clk_i, rst_ni, (s2_valid_q && !s2_adv) |-> out_valid_q)
  `CPU16EU_ASSERT(a_ip_holds, clk_i, rst_ni, !s2_adv |=> $stable(ip_q))

endmodule
